// File: hw/rtl/dqpb_pkg.sv
// ============================================================================
// DNS query packet builder package
// Shared constants, datapath operation codes, command and status structures.
// ============================================================================
package dqpb_pkg;

    // Packet layout constants
    localparam int unsigned HDR_LEN    = 12;
    localparam int unsigned ARPA_LEN   = 13;
    localparam int unsigned TAIL_LEN   = 5;
    localparam int unsigned MAX_NAME   = 255;
    localparam int unsigned ADDR_CHARS = 16;
    localparam int unsigned ADDR_W     = $clog2(ADDR_CHARS);
    localparam int unsigned LABEL_MAX  = 63;
    localparam int unsigned CNT_W      = 4;

    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] QTYPE_A   = 8'h01;
    localparam logic [7:0] QTYPE_PTR = 8'h0C;
    localparam logic [7:0] QCLASS_IN = 8'h01;

    // Datapath operation codes
    typedef logic [3:0] dqpb_op_t;
    localparam dqpb_op_t OP_NONE  = 4'd0;
    localparam dqpb_op_t OP_LOAD  = 4'd1;
    localparam dqpb_op_t OP_HDR   = 4'd2;
    localparam dqpb_op_t OP_FCHAR = 4'd3;
    localparam dqpb_op_t OP_CLOSE = 4'd4;
    localparam dqpb_op_t OP_ERROR = 4'd5;
    localparam dqpb_op_t OP_BUFWR = 4'd6;
    localparam dqpb_op_t OP_RSTEP = 4'd7;
    localparam dqpb_op_t OP_RLEN  = 4'd8;
    localparam dqpb_op_t OP_RBYTE = 4'd9;
    localparam dqpb_op_t OP_ARPA  = 4'd10;
    localparam dqpb_op_t OP_TAIL  = 4'd11;
    localparam dqpb_op_t OP_MARK  = 4'd12;

    // Controller to datapath
    typedef struct packed {
        dqpb_op_t op;
        logic     mem_rd;   // read the address buffer this cycle
        logic     rd_byte;  // 1: read at the byte pointer, 0: at the scan pointer
    } dqpb_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic first_pending;
        logic error_seen;
        logic reverse_mode;
        logic last_char;
        logic is_dot;
        logic count_zero;
        logic label_full;
        logic fits_char;
        logic fits_dot;
        logic buf_full;
        logic hdr_done;
        logic arpa_done;
        logic tail_done;
        logic p_zero;
        logic rd_is_dot;
        logic seg_nonempty;
        logic k_more;
        logic out_free;
    } dqpb_stat_t;

    // Fixed header bytes; the ID comes from the configuration register.
    function automatic logic [7:0] hdr_byte(input logic [CNT_W-1:0] idx,
                                            input logic [15:0] id);
        logic [7:0] b;
        b = 8'h00;
        case (idx)
            4'd0:    b = id[15:8];
            4'd1:    b = id[7:0];
            4'd2:    b = 8'h01;
            4'd5:    b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Encoded "in-addr.arpa" suffix.
    function automatic logic [7:0] arpa_byte(input logic [CNT_W-1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (idx)
            4'd0:    b = 8'd7;
            4'd1:    b = "i";
            4'd2:    b = "n";
            4'd3:    b = "-";
            4'd4:    b = "a";
            4'd5:    b = "d";
            4'd6:    b = "d";
            4'd7:    b = "r";
            4'd8:    b = 8'd4;
            4'd9:    b = "a";
            4'd10:   b = "r";
            4'd11:   b = "p";
            4'd12:   b = "a";
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: hw/rtl/dqpb_ctrl.sv
// ============================================================================
// DNS query packet builder controller
// Sequences header, label encoding, reverse address scan and packet tail.
// ============================================================================
module dqpb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  dqpb_pkg::dqpb_stat_t stat,
    output dqpb_pkg::dqpb_cmd_t  cmd
);
    import dqpb_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HDR   = 4'd1;
    localparam logic [3:0] S_CHAR  = 4'd2;
    localparam logic [3:0] S_CLOSE = 4'd3;
    localparam logic [3:0] S_TAIL  = 4'd4;
    localparam logic [3:0] S_MARK  = 4'd5;
    localparam logic [3:0] S_RSCAN = 4'd6;
    localparam logic [3:0] S_RCHK  = 4'd7;
    localparam logic [3:0] S_RLEN  = 4'd8;
    localparam logic [3:0] S_KRD   = 4'd9;
    localparam logic [3:0] S_RBYTE = 4'd10;
    localparam logic [3:0] S_ARPA  = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // Next state and datapath command.
    always_comb
    begin
        state_next  = state_reg;
        cmd.op      = OP_NONE;
        cmd.mem_rd  = 1'b0;
        cmd.rd_byte = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = stat.first_pending ? S_HDR : S_CHAR;
                end
            end
            S_HDR:
            begin
                if (stat.out_free)
                begin
                    cmd.op = OP_HDR;
                    if (stat.hdr_done)
                    begin
                        state_next = S_CHAR;
                    end
                end
            end
            S_CHAR:
            begin
                if (stat.error_seen)
                begin
                    state_next = stat.last_char ? S_MARK : S_IDLE;
                end
                else if (stat.reverse_mode)
                begin
                    if (stat.buf_full)
                    begin
                        cmd.op     = OP_ERROR;
                        state_next = stat.last_char ? S_MARK : S_IDLE;
                    end
                    else
                    begin
                        cmd.op     = OP_BUFWR;
                        state_next = stat.last_char ? S_RSCAN : S_IDLE;
                    end
                end
                else if (stat.is_dot)
                begin
                    // A final dot after a closed label only marks the root.
                    if (stat.last_char && stat.count_zero)
                    begin
                        state_next = S_TAIL;
                    end
                    else if (!stat.fits_dot)
                    begin
                        cmd.op     = OP_ERROR;
                        state_next = stat.last_char ? S_MARK : S_IDLE;
                    end
                    else if (stat.out_free)
                    begin
                        cmd.op     = OP_CLOSE;
                        state_next = stat.last_char ? S_TAIL : S_IDLE;
                    end
                end
                else if (stat.label_full || !stat.fits_char)
                begin
                    cmd.op     = OP_ERROR;
                    state_next = stat.last_char ? S_MARK : S_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.op     = OP_FCHAR;
                    state_next = stat.last_char ? S_CLOSE : S_IDLE;
                end
            end
            S_CLOSE:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_CLOSE;
                    state_next = S_TAIL;
                end
            end
            S_RSCAN:
            begin
                if (stat.p_zero)
                begin
                    state_next = S_RLEN;
                end
                else
                begin
                    cmd.mem_rd = 1'b1;
                    state_next = S_RCHK;
                end
            end
            S_RCHK:
            begin
                if (stat.rd_is_dot)
                begin
                    state_next = S_RLEN;
                end
                else
                begin
                    cmd.op     = OP_RSTEP;
                    state_next = S_RSCAN;
                end
            end
            S_RLEN:
            begin
                if (stat.out_free)
                begin
                    cmd.op = OP_RLEN;
                    if (stat.seg_nonempty)
                    begin
                        state_next = S_KRD;
                    end
                    else
                    begin
                        state_next = stat.p_zero ? S_ARPA : S_RSCAN;
                    end
                end
            end
            S_KRD:
            begin
                cmd.mem_rd  = 1'b1;
                cmd.rd_byte = 1'b1;
                state_next  = S_RBYTE;
            end
            S_RBYTE:
            begin
                if (stat.out_free)
                begin
                    cmd.op = OP_RBYTE;
                    if (stat.k_more)
                    begin
                        state_next = S_KRD;
                    end
                    else
                    begin
                        state_next = stat.p_zero ? S_ARPA : S_RSCAN;
                    end
                end
            end
            S_ARPA:
            begin
                if (stat.out_free)
                begin
                    cmd.op = OP_ARPA;
                    if (stat.arpa_done)
                    begin
                        state_next = S_TAIL;
                    end
                end
            end
            S_TAIL:
            begin
                if (stat.out_free)
                begin
                    cmd.op = OP_TAIL;
                    if (stat.tail_done)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_MARK:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_MARK;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/dqpb_datapath.sv
// ============================================================================
// DNS query packet builder datapath
// Name state, address buffer, sequence counters and the output register.
// ============================================================================
module dqpb_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [15:0]          cfg_wr_data,
    input  logic [7:0]           char_byte,
    input  logic                 last_char,
    input  logic                 reverse_lookup,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [8:0]           byte_offset,
    output logic [7:0]           byte_value,
    output logic                 last_byte,
    output logic                 name_error,
    input  dqpb_pkg::dqpb_cmd_t  cmd,
    output dqpb_pkg::dqpb_stat_t stat
);
    import dqpb_pkg::*;

    localparam logic [9:0] FIT_LIMIT = 10'(MAX_NAME + 10);

    // Configuration and item registers
    logic [15:0]       query_id_reg;
    logic [7:0]        char_reg;
    logic              last_reg;

    // Name encoding state
    logic [8:0]        label_start_reg;
    logic [5:0]        label_count_reg;
    logic [ADDR_W-1:0] addr_count_reg;
    logic              reverse_mode_reg;
    logic              first_pending_reg;
    logic              error_seen_reg;

    // Sequencing: phase counter, scan pointer, segment end, byte pointer
    logic [CNT_W-1:0]  cnt_reg;
    logic [ADDR_W-1:0] p_reg;
    logic [ADDR_W-1:0] end_reg;
    logic [ADDR_W-1:0] k_reg;

    // Address buffer
    logic [7:0]        addr_mem [ADDR_CHARS];
    logic [7:0]        rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;

    // Output register
    logic              out_valid_reg;
    logic [8:0]        out_off_reg;
    logic [7:0]        out_val_reg;
    logic              out_last_reg;
    logic              out_err_reg;

    logic              emit;
    logic [8:0]        emit_off;
    logic [7:0]        emit_val;
    logic              emit_last;
    logic              emit_err;
    logic              restart;
    logic [7:0]        qtype;
    logic              close_seg;
    logic [ADDR_W:0]   k_plus;

    // Status toward the controller.
    assign k_plus              = {1'b0, k_reg} + 1'b1;
    assign stat.first_pending  = first_pending_reg;
    assign stat.error_seen     = error_seen_reg;
    assign stat.reverse_mode   = reverse_mode_reg;
    assign stat.last_char      = last_reg;
    assign stat.is_dot         = (char_reg == CHAR_DOT);
    assign stat.count_zero     = (label_count_reg == 6'd0);
    assign stat.label_full     = (label_count_reg == 6'(LABEL_MAX));
    assign stat.fits_char      = ({1'b0, label_start_reg} + 10'(label_count_reg) + 10'd1)
                                 <= FIT_LIMIT;
    assign stat.fits_dot       = ({1'b0, label_start_reg} <= FIT_LIMIT);
    assign stat.buf_full       = (addr_count_reg == ADDR_W'(ADDR_CHARS - 1));
    assign stat.hdr_done       = (cnt_reg == CNT_W'(HDR_LEN - 1));
    assign stat.arpa_done      = (cnt_reg == CNT_W'(ARPA_LEN - 1));
    assign stat.tail_done      = (cnt_reg == CNT_W'(TAIL_LEN - 1));
    assign stat.p_zero         = (p_reg == '0);
    assign stat.rd_is_dot      = (rd_data_reg == CHAR_DOT);
    assign stat.seg_nonempty   = (p_reg < end_reg);
    assign stat.k_more         = (k_plus < {1'b0, end_reg});
    assign stat.out_free       = !out_valid_reg || out_ready;

    assign qtype   = reverse_mode_reg ? QTYPE_PTR : QTYPE_A;
    assign restart = (cmd.op == OP_MARK) || ((cmd.op == OP_TAIL) && stat.tail_done);

    // A finished reverse segment moves the scan past its dot.
    assign close_seg = !stat.p_zero &&
                       (((cmd.op == OP_RLEN) && !stat.seg_nonempty) ||
                        ((cmd.op == OP_RBYTE) && !stat.k_more));

    // Result byte selection.
    always_comb
    begin
        emit      = 1'b1;
        emit_off  = label_start_reg;
        emit_val  = 8'h00;
        emit_last = 1'b0;
        emit_err  = 1'b0;
        case (cmd.op)
            OP_HDR:
            begin
                emit_off = 9'(cnt_reg);
                emit_val = hdr_byte(cnt_reg, query_id_reg);
            end
            OP_FCHAR:
            begin
                emit_off = label_start_reg + 9'(label_count_reg) + 9'd1;
                emit_val = char_reg;
            end
            OP_CLOSE:
            begin
                emit_val = 8'(label_count_reg);
            end
            OP_RLEN:
            begin
                emit_val = 8'(end_reg - p_reg);
            end
            OP_RBYTE:
            begin
                emit_val = rd_data_reg;
            end
            OP_ARPA:
            begin
                emit_val = arpa_byte(cnt_reg);
            end
            OP_TAIL:
            begin
                emit_off  = label_start_reg + 9'(cnt_reg);
                emit_last = stat.tail_done;
                if (cnt_reg == 4'd2)
                begin
                    emit_val = qtype;
                end
                else if (stat.tail_done)
                begin
                    emit_val = QCLASS_IN;
                end
            end
            OP_MARK:
            begin
                emit_off  = 9'd0;
                emit_last = 1'b1;
                emit_err  = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_id_reg <= 16'h0000;
        end
        else if (cfg_wr_en)
        begin
            query_id_reg <= cfg_wr_data;
        end
    end

    // Item payload, latched on transfer.
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            char_reg <= char_byte;
            last_reg <= last_char;
        end
    end

    // Name encoding state and sequencing counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            label_start_reg   <= 9'(HDR_LEN);
            label_count_reg   <= '0;
            addr_count_reg    <= '0;
            reverse_mode_reg  <= 1'b0;
            first_pending_reg <= 1'b1;
            error_seen_reg    <= 1'b0;
            cnt_reg           <= '0;
            p_reg             <= '0;
            end_reg           <= '0;
            k_reg             <= '0;
        end
        else if (restart)
        begin
            label_start_reg   <= 9'(HDR_LEN);
            label_count_reg   <= '0;
            addr_count_reg    <= '0;
            reverse_mode_reg  <= 1'b0;
            first_pending_reg <= 1'b1;
            error_seen_reg    <= 1'b0;
            cnt_reg           <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_LOAD:
                begin
                    if (first_pending_reg)
                    begin
                        reverse_mode_reg  <= reverse_lookup;
                        first_pending_reg <= 1'b0;
                    end
                end
                OP_HDR:
                begin
                    cnt_reg <= stat.hdr_done ? '0 : cnt_reg + 1'b1;
                end
                OP_FCHAR:
                begin
                    label_count_reg <= label_count_reg + 6'd1;
                end
                OP_CLOSE:
                begin
                    label_start_reg <= label_start_reg + 9'(label_count_reg) + 9'd1;
                    label_count_reg <= '0;
                end
                OP_ERROR:
                begin
                    error_seen_reg <= 1'b1;
                end
                OP_BUFWR:
                begin
                    addr_count_reg <= addr_count_reg + 1'b1;
                    p_reg          <= addr_count_reg + 1'b1;
                    end_reg        <= addr_count_reg + 1'b1;
                end
                OP_RSTEP:
                begin
                    p_reg <= p_reg - 1'b1;
                end
                OP_RLEN:
                begin
                    label_start_reg <= label_start_reg + 9'd1;
                    k_reg           <= p_reg;
                end
                OP_RBYTE:
                begin
                    label_start_reg <= label_start_reg + 9'd1;
                    k_reg           <= k_plus[ADDR_W-1:0];
                end
                OP_ARPA:
                begin
                    label_start_reg <= label_start_reg + 9'd1;
                    cnt_reg         <= stat.arpa_done ? '0 : cnt_reg + 1'b1;
                end
                OP_TAIL:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                default:
                begin
                end
            endcase
            if (close_seg)
            begin
                end_reg <= p_reg - 1'b1;
                p_reg   <= p_reg - 1'b1;
            end
        end
    end

    // Address buffer: one write port, one registered read port.
    assign rd_addr = cmd.rd_byte ? k_reg : p_reg - 1'b1;

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_BUFWR)
        begin
            addr_mem[addr_count_reg] <= char_reg;
        end
        if (cmd.mem_rd)
        begin
            rd_data_reg <= addr_mem[rd_addr];
        end
    end

    // Output register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_off_reg  <= emit_off;
            out_val_reg  <= emit_val;
            out_last_reg <= emit_last;
            out_err_reg  <= emit_err;
        end
    end

    assign out_valid   = out_valid_reg;
    assign byte_offset = out_off_reg;
    assign byte_value  = out_val_reg;
    assign last_byte   = out_last_reg;
    assign name_error  = out_err_reg;

endmodule

// File: hw/rtl/dns_query_packet_builder.sv
// ============================================================================
// DNS query packet builder
// Encodes a dotted query name, one character per transfer, into DNS query
// packet bytes given as offset and value pairs.
// ============================================================================
//
//  Channel   Handshake              Payload
//  -------   ---------------------  ------------------------------------------
//  config    cfg_wr_en              cfg_wr_data (query ID)
//  input     in_valid / in_ready    char_byte, last_char, reverse_lookup
//  output    out_valid / out_ready  byte_offset, byte_value, last_byte,
//                                   name_error
//
//  A forward-mode character is taken in the idle state and encoded in the
//  character state. The first character of a query first passes the header state.
//  A reverse lookup ends with a scan of the address buffer through its single
//  read port: a backward search for each dot, then a length byte and the copied
//  bytes of each segment, then the suffix bytes and the tail bytes.
//  Any emitting step waits while the output register holds an untaken byte.
//  Reset clears all query state; the final byte of each packet restores it.
//
module dns_query_packet_builder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_byte,
    input  logic        last_char,
    input  logic        reverse_lookup,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [8:0]  byte_offset,
    output logic [7:0]  byte_value,
    output logic        last_byte,
    output logic        name_error
);
    import dqpb_pkg::*;

    dqpb_cmd_t  cmd;
    dqpb_stat_t stat;

    // Sequencer.
    dqpb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath.
    dqpb_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .char_byte      (char_byte),
        .last_char      (last_char),
        .reverse_lookup (reverse_lookup),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .byte_offset    (byte_offset),
        .byte_value     (byte_value),
        .last_byte      (last_byte),
        .name_error     (name_error),
        .cmd            (cmd),
        .stat           (stat)
    );

    // The error marker is always a zero byte at offset zero that ends the packet.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && name_error |-> last_byte && byte_offset == 9'd0 && byte_value == 8'd0)
        else $error("error marker carries wrong fields");

    // A good packet never ends before the shortest tail, which finishes at offset 16.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_byte && !name_error |-> byte_offset >= 9'd16)
        else $error("packet ended inside header or name");

    // Every accepted character is worked on before the next one is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken on consecutive cycles");

    // The backward search never reads below the start of the buffer.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_rd && !cmd.rd_byte |-> !stat.p_zero)
        else $error("address scan read below buffer start");

    // A byte is loaded only into a free output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_HDR || cmd.op == OP_FCHAR || cmd.op == OP_CLOSE ||
         cmd.op == OP_RLEN || cmd.op == OP_RBYTE || cmd.op == OP_ARPA ||
         cmd.op == OP_TAIL || cmd.op == OP_MARK) |-> stat.out_free)
        else $error("output register overwritten");

endmodule

// File: sim/tb_dns_query_packet_builder.sv
`timescale 1ns / 1ps
// ============================================================================
// DNS query packet builder testbench
// Feeds dotted names and IPv4 addresses one character per transfer and checks
// every packet byte against a predictor of the encoder, under random and
// long output stalls, across several query ID settings.
// ============================================================================

// Predicts the packet bytes and checks those the block delivers, in order.
class packet_byte_tracker;

    typedef struct packed {
        logic [8:0] offset;
        logic [7:0] value;
        logic       last;
        logic       error;
    } packet_byte_t;

    localparam logic [15:0] FLAGS_RD    = 16'h0100;
    localparam logic [15:0] ONE_QUESTION = 16'h0001;
    localparam string       PTR_SUFFIX  = "in-addr.arpa";

    packet_byte_t pending_bytes[$];
    int           errors;
    logic [15:0]  query_id;
    int           label_start;
    int           label_len;
    int           addr_len;
    logic [7:0]   addr_chars[dqpb_pkg::ADDR_CHARS];
    bit           ptr_query;
    bit           header_due;
    bit           failed;

    function new();
        errors   = 0;
        query_id = '0;
        start_query();
    endfunction

    // State for the next query; the query ID is kept.
    function void start_query();
        label_start = dqpb_pkg::HDR_LEN;
        label_len   = 0;
        addr_len    = 0;
        ptr_query   = 1'b0;
        header_due  = 1'b1;
        failed      = 1'b0;
    endfunction

    function void emit(int off, int val, bit last, bit err);
        packet_byte_t b;
        b.offset = off[8:0];
        b.value  = val[7:0];
        b.last   = last;
        b.error  = err;
        pending_bytes.push_back(b);
    endfunction

    // A name byte at this offset must still leave room for the terminator.
    function bit name_fits(int off);
        return (off - int'(dqpb_pkg::HDR_LEN) + 2) <= int'(dqpb_pkg::MAX_NAME);
    endfunction

    function void close_label();
        emit(label_start, label_len, 1'b0, 1'b0);
        label_start = label_start + label_len + 1;
        label_len   = 0;
    endfunction

    function void emit_question(int off, logic [7:0] qtype);
        emit(off, 0, 1'b0, 1'b0);
        emit(off + 1, 0, 1'b0, 1'b0);
        emit(off + 2, qtype, 1'b0, 1'b0);
        emit(off + 3, 0, 1'b0, 1'b0);
        emit(off + 4, dqpb_pkg::QCLASS_IN, 1'b1, 1'b0);
    endfunction

    function void encode_forward(logic [7:0] c, bit last);
        if (c == dqpb_pkg::CHAR_DOT) begin
            // A final dot only marks the root; it adds no empty label.
            if (last && label_len == 0)
                return;
            if (!name_fits(label_start))
                failed = 1'b1;
            else
                close_label();
            return;
        end
        if (label_len >= int'(dqpb_pkg::LABEL_MAX) ||
            !name_fits(label_start + 1 + label_len)) begin
            failed = 1'b1;
            return;
        end
        emit(label_start + 1 + label_len, c, 1'b0, 1'b0);
        label_len++;
        if (last)
            close_label();
    endfunction

    // Reversed address labels, then the in-addr.arpa suffix and a PTR question.
    function void encode_reverse();
        int off;
        int seg_end;
        int i;
        int k;
        int seg_start;
        bit boundary;
        off     = dqpb_pkg::HDR_LEN;
        seg_end = addr_len;
        for (i = addr_len - 1; i >= -1; i--) begin
            if (i < 0)
                boundary = 1'b1;
            else
                boundary = (addr_chars[i] == dqpb_pkg::CHAR_DOT);
            if (boundary) begin
                emit(off, seg_end - i - 1, 1'b0, 1'b0);
                off++;
                for (k = i + 1; k < seg_end; k++) begin
                    emit(off, addr_chars[k], 1'b0, 1'b0);
                    off++;
                end
                seg_end = i;
            end
        end
        seg_start = 0;
        for (i = 0; i <= PTR_SUFFIX.len(); i++) begin
            if (i == PTR_SUFFIX.len() || PTR_SUFFIX[i] == "." ) begin
                emit(off, i - seg_start, 1'b0, 1'b0);
                off++;
                for (k = seg_start; k < i; k++) begin
                    emit(off, PTR_SUFFIX[k], 1'b0, 1'b0);
                    off++;
                end
                seg_start = i + 1;
            end
        end
        emit_question(off, dqpb_pkg::QTYPE_PTR);
    endfunction

    // Notes one accepted character and queues the bytes it produces.
    function void take_char(logic [7:0] c, logic last, logic rev);
        logic [15:0] words[6];
        int          w;
        if (header_due) begin
            ptr_query  = rev;
            header_due = 1'b0;
            words = '{query_id, FLAGS_RD, ONE_QUESTION, 16'h0000, 16'h0000, 16'h0000};
            for (w = 0; w < 6; w++) begin
                emit(2 * w, words[w][15:8], 1'b0, 1'b0);
                emit(2 * w + 1, words[w][7:0], 1'b0, 1'b0);
            end
        end
        if (!failed) begin
            if (ptr_query) begin
                if (addr_len >= int'(dqpb_pkg::ADDR_CHARS) - 1) begin
                    failed = 1'b1;
                end
                else begin
                    addr_chars[addr_len] = c;
                    addr_len++;
                end
            end
            else begin
                encode_forward(c, last);
            end
        end
        if (last) begin
            if (failed)
                emit(0, 0, 1'b1, 1'b1);
            else if (ptr_query)
                encode_reverse();
            else
                emit_question(label_start, dqpb_pkg::QTYPE_A);
            start_query();
        end
    endfunction

    // Compares one delivered byte with the oldest prediction.
    function void check_byte(logic [8:0] off, logic [7:0] val, logic last, logic err);
        packet_byte_t got;
        packet_byte_t want;
        got = '{off, val, last, err};
        if (pending_bytes.size() == 0) begin
            errors++;
            if (errors <= 50)
                $display("%0t ns: unexpected byte, expected none, got off %0d val 0x%02h last %0b err %0b",
                         $time, off, val, last, err);
            return;
        end
        want = pending_bytes.pop_front();
        if (got !== want) begin
            errors++;
            if (errors <= 50)
                $display("%0t ns: byte mismatch, expected off %0d val 0x%02h last %0b err %0b, got off %0d val 0x%02h last %0b err %0b",
                         $time, want.offset, want.value, want.last, want.error,
                         got.offset, got.value, got.last, got.error);
        end
    endfunction

    function int pending();
        return pending_bytes.size();
    endfunction

endclass

module tb_dns_query_packet_builder;

    import dqpb_pkg::*;

    localparam int          SETTLE_CYCLES = 64;
    localparam int          HOLD_CYCLES   = 400;
    localparam logic [7:0]  LOWER_A       = "a";
    localparam logic [7:0]  DIGIT_ZERO    = "0";
    localparam logic [7:0]  HYPHEN        = "-";

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        cfg_wr_en      = 1'b0;
    logic [15:0] cfg_wr_data    = '0;
    logic        in_valid       = 1'b0;
    logic        in_ready;
    logic [7:0]  char_byte      = '0;
    logic        last_char      = 1'b0;
    logic        reverse_lookup = 1'b0;
    logic        out_valid;
    logic        out_ready      = 1'b0;
    logic [8:0]  byte_offset;
    logic [7:0]  byte_value;
    logic        last_byte;
    logic        name_error;

    packet_byte_tracker tracker = new();

    logic [7:0] name_chars[$];
    int         send_idle_pct = 8;
    int         recv_idle_pct = 62;
    int         chars_sent    = 0;
    int         hold_token    = 0;

    dns_query_packet_builder u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .char_byte      (char_byte),
        .last_char      (last_char),
        .reverse_lookup (reverse_lookup),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .byte_offset    (byte_offset),
        .byte_value     (byte_value),
        .last_byte      (last_byte),
        .name_error     (name_error)
    );

    // Clock generation.
    initial
    begin
        forever #6 clk = ~clk;
    end

    // Overall time limit.
    initial
    begin
        #3000000;
        $display("tb_dns_query_packet_builder: done, errors");
        $finish;
    end

    // Sample both channels at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_byte(byte_offset, byte_value, last_byte, name_error);
        if (rst_n && in_valid && in_ready)
            tracker.take_char(char_byte, last_char, reverse_lookup);
    end

    // Receiver: random stalls, plus a long hold-off on request.
    initial
    begin
        int hold_seen;
        hold_seen = 0;
        forever
        begin
            @(negedge clk);
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offers one character and returns at the falling edge after its transfer.
    task automatic send_char(input logic [7:0] c, input logic last, input logic rev);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        char_byte      <= c;
        last_char      <= last;
        reverse_lookup <= rev;
        do @(posedge clk); while (!in_ready);
        chars_sent++;
        @(negedge clk);
    endtask

    // Sends the characters in name_chars as one query.
    task automatic run_query(input bit rev);
        int i;
        for (i = 0; i < name_chars.size(); i++)
            send_char(name_chars[i], i == name_chars.size() - 1,
                      (i == 0) ? rev : 1'($urandom_range(1)));
    endtask

    // Stops sending and waits until every predicted byte has come out.
    task automatic wait_packets_done();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes the query ID; the block is idle here.
    task automatic set_query_id(input logic [15:0] id);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= id;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        tracker.query_id = id;
        @(negedge clk);
    endtask

    task automatic load_text(input string s);
        int i;
        name_chars.delete();
        for (i = 0; i < s.len(); i++)
            name_chars.push_back(s[i]);
    endtask

    // Appends a label of mostly host-name characters, never a dot.
    task automatic add_label(input int len);
        int         i;
        int         pick;
        logic [7:0] c;
        for (i = 0; i < len; i++) begin
            pick = $urandom_range(99);
            if (pick < 70)
                c = LOWER_A + 8'($urandom_range(25));
            else if (pick < 85)
                c = DIGIT_ZERO + 8'($urandom_range(9));
            else if (pick < 90)
                c = HYPHEN;
            else
                c = 8'($urandom_range(255));
            if (c == CHAR_DOT)
                c = LOWER_A;
            name_chars.push_back(c);
        end
    endtask

    task automatic add_octet(input int v);
        if (v >= 100)
            name_chars.push_back(DIGIT_ZERO + 8'(v / 100));
        if (v >= 10)
            name_chars.push_back(DIGIT_ZERO + 8'((v / 10) % 10));
        name_chars.push_back(DIGIT_ZERO + 8'(v % 10));
    endtask

    // Builds one random query: mostly well-formed names and addresses.
    task automatic make_random_query(output bit rev);
        int kind;
        int n;
        int i;
        name_chars.delete();
        kind = $urandom_range(99);
        rev  = 1'b0;
        if (kind < 50) begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++) begin
                if (i != 0)
                    name_chars.push_back(CHAR_DOT);
                add_label($urandom_range(0, 12));
            end
            if ($urandom_range(3) == 0 || name_chars.size() == 0)
                name_chars.push_back(CHAR_DOT);
        end
        else if (kind < 82) begin
            rev = 1'b1;
            for (i = 0; i < 4; i++) begin
                if (i != 0)
                    name_chars.push_back(CHAR_DOT);
                // Now and then an empty octet.
                if ($urandom_range(9) != 0)
                    add_octet($urandom_range(255));
            end
            // Now and then more characters than the address buffer holds.
            if ($urandom_range(7) == 0)
                while (name_chars.size() < 17)
                    name_chars.push_back(DIGIT_ZERO + 8'($urandom_range(9)));
        end
        else if (kind < 86) begin
            add_label($urandom_range(60, 66));
            name_chars.push_back(CHAR_DOT);
            add_label($urandom_range(1, 3));
        end
        else begin
            rev = 1'($urandom_range(1));
            n   = $urandom_range(1, 6);
            for (i = 0; i < n; i++)
                name_chars.push_back(8'($urandom_range(255)));
        end
    endtask

    task automatic random_queries(input int count);
        int first;
        bit rev;
        first = chars_sent;
        while (chars_sent - first < count) begin
            make_random_query(rev);
            run_query(rev);
        end
    endtask

    // Main stimulus.
    initial
    begin
        int i;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed queries with all-ones ID.
        set_query_id(16'hFFFF);
        name_chars.delete();
        name_chars.push_back(8'h00);
        name_chars.push_back(8'hFF);
        run_query(1'b0);
        load_text(".");
        run_query(1'b0);
        load_text("a..b.");
        run_query(1'b0);
        load_text("1.2.3.4");
        run_query(1'b1);
        load_text("1..2");
        run_query(1'b1);
        load_text("7");
        run_query(1'b1);
        wait_packets_done();

        // Label, name and address buffer limits with a zero ID.
        set_query_id(16'h0000);
        name_chars.delete();
        add_label(LABEL_MAX);
        name_chars.push_back(CHAR_DOT);
        add_label(2);
        run_query(1'b0);
        name_chars.delete();
        add_label(LABEL_MAX + 1);
        name_chars.push_back(CHAR_DOT);
        add_label(2);
        run_query(1'b0);
        load_text("192.168.100.2001");
        run_query(1'b1);
        load_text("255.255.255.255");
        run_query(1'b1);
        // Longest name that fits, ending in a root dot.
        name_chars.delete();
        for (i = 0; i < 4; i++) begin
            add_label((i < 3) ? LABEL_MAX : LABEL_MAX - 2);
            name_chars.push_back(CHAR_DOT);
        end
        run_query(1'b0);
        // One character past the longest name.
        name_chars.delete();
        for (i = 0; i < 4; i++) begin
            if (i != 0)
                name_chars.push_back(CHAR_DOT);
            add_label((i < 3) ? LABEL_MAX : LABEL_MAX - 1);
        end
        run_query(1'b0);
        wait_packets_done();

        // Random queries, receiver mostly stalled.
        set_query_id(16'($urandom_range(16'hFFFF)));
        random_queries(45);
        wait_packets_done();

        // Random queries, sender mostly idle.
        send_idle_pct = 62;
        recv_idle_pct = 8;
        set_query_id(16'h8001);
        random_queries(45);
        wait_packets_done();

        // No idling; a long output hold-off while a name keeps arriving.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_query_id(16'($urandom_range(16'hFFFF)));
        hold_token++;
        name_chars.delete();
        add_label(20);
        name_chars.push_back(CHAR_DOT);
        add_label(20);
        run_query(1'b0);
        wait_packets_done();
        random_queries(40);
        wait_packets_done();

        if (tracker.errors == 0)
            $display("tb_dns_query_packet_builder: done, clean");
        else
            $display("tb_dns_query_packet_builder: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/dqpb_pkg.sv
hw/rtl/dqpb_ctrl.sv
hw/rtl/dqpb_datapath.sv
hw/rtl/dns_query_packet_builder.sv
sim/tb_dns_query_packet_builder.sv
